>>> src/fsmt_pkg.sv
`timescale 1ns / 1ps

package fsmt_pkg;

   localparam int SLOTS_DEF  = 512;

   localparam int OP_W       = 3;
   localparam int ID_W       = 16;
   localparam int SLOT_W     = 9;
   localparam int STATUS_W   = 2;
   localparam int SECTOR_W   = 24;
   localparam int COUNT_W    = 16;
   localparam int LCOUNT_W   = 10;
   localparam int SHIFT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
   localparam logic [OP_W-1:0] OP_RECORD = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_SCRUB  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] IDX_FIRST_SECTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_LOGICAL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_GROUP_SHIFT   = 2'd2;

   localparam logic [SECTOR_W-1:0] FIRST_SECTOR_RST  = 24'd0;
   localparam logic [LCOUNT_W-1:0] LOGICAL_COUNT_RST = 10'd512;
   localparam logic [SHIFT_W-1:0]  GROUP_SHIFT_RST   = 3'd0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [SECTOR_W-1:0] first_sector;
      logic [LCOUNT_W-1:0] logical_count;
      logic [SHIFT_W-1:0]  group_shift;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    owner;
      logic [COUNT_W-1:0] writes;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   found_slot;
      logic [SECTOR_W-1:0] flash_sector;
      logic [COUNT_W-1:0]  write_count;
   } res_type;

endpackage

>>> src/fsmt_if.sv
`timescale 1ns / 1ps

interface fsmt_req_if;
   logic                         valid;
   logic                         ready;
   logic [fsmt_pkg::OP_W-1:0]    operation;
   logic [fsmt_pkg::ID_W-1:0]    map_id;
   logic [fsmt_pkg::SLOT_W-1:0]  slot;
   logic [fsmt_pkg::SLOT_W-1:0]  slot_end;

   modport source (output valid, operation, map_id, slot, slot_end, input ready);
   modport sink   (input valid, operation, map_id, slot, slot_end, output ready);
endinterface

interface fsmt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fsmt_pkg::STATUS_W-1:0]  status;
   logic [fsmt_pkg::SLOT_W-1:0]    found_slot;
   logic [fsmt_pkg::SECTOR_W-1:0]  flash_sector;
   logic [fsmt_pkg::COUNT_W-1:0]   write_count;

   modport source (output valid, status, found_slot, flash_sector, write_count,
                   input ready);
   modport sink   (input valid, status, found_slot, flash_sector, write_count,
                   output ready);
endinterface

interface fsmt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fsmt_pkg::CSR_IDX_W-1:0]   index;
   logic [fsmt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/fsmt_csr.sv
`timescale 1ns / 1ps

module fsmt_csr (
   input  logic              clock,
   input  logic              reset,
   fsmt_csr_if.sink          csr_ch,
   output fsmt_pkg::cfg_type cfg
);

   fsmt_pkg::cfg_type cfg_ff;
   fsmt_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            fsmt_pkg::IDX_FIRST_SECTOR: begin
               cfg_in.first_sector = csr_ch.data[fsmt_pkg::SECTOR_W-1:0];
            end
            fsmt_pkg::IDX_LOGICAL_COUNT: begin
               cfg_in.logical_count = csr_ch.data[fsmt_pkg::LCOUNT_W-1:0];
            end
            fsmt_pkg::IDX_GROUP_SHIFT: begin
               cfg_in.group_shift = csr_ch.data[fsmt_pkg::SHIFT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_sector  <= fsmt_pkg::FIRST_SECTOR_RST;
         cfg_ff.logical_count <= fsmt_pkg::LOGICAL_COUNT_RST;
         cfg_ff.group_shift   <= fsmt_pkg::GROUP_SHIFT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/fsmt_mem.sv
`timescale 1ns / 1ps

module fsmt_mem #(
   parameter  int SLOTS = fsmt_pkg::SLOTS_DEF,
   localparam int AW    = $clog2(SLOTS)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  fsmt_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output fsmt_pkg::entry_type rd_data
);

   fsmt_pkg::entry_type store [SLOTS];
   fsmt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fsmt_ctrl.sv
`timescale 1ns / 1ps

module fsmt_ctrl #(
   parameter  int SLOTS = fsmt_pkg::SLOTS_DEF,
   localparam int AW    = $clog2(SLOTS),
   localparam int NW    = $clog2(SLOTS + 1),
   localparam int PW    = (NW > fsmt_pkg::SLOT_W + 1) ? NW : fsmt_pkg::SLOT_W + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  fsmt_pkg::cfg_type   cfg,
   fsmt_req_if.sink            req_ch,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output fsmt_pkg::entry_type mem_wr_data,
   output logic [AW-1:0]       mem_rd_addr,
   input  fsmt_pkg::entry_type mem_rd_data,
   output logic                res_valid,
   output fsmt_pkg::res_type   res,
   input  logic                res_take
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DEL   = 3'd3;
   localparam logic [2:0] S_ISSUE = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [PW-1:0]                 cur_ff, cur_in;
   logic [AW-1:0]                 chk_ff, chk_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic                          down_ff, down_in;
   logic [fsmt_pkg::OP_W-1:0]     op_ff, op_in;
   logic [fsmt_pkg::ID_W-1:0]     id_ff, id_in;
   logic [PW-1:0]                 start_ff, start_in;
   logic [fsmt_pkg::SLOT_W-1:0]   end_ff, end_in;
   fsmt_pkg::res_type             res_ff, res_in;

   logic [NW-1:0]                 active_n;
   logic [PW-1:0]                 active_p;
   logic [PW-1:0]                 limit;
   logic [PW-1:0]                 slot_p;
   logic [PW-1:0]                 start_w;
   logic                          in_range;
   logic                          match_id;
   logic                          stale;
   logic                          hit;
   logic [fsmt_pkg::COUNT_W-1:0]  next_writes;

   function automatic fsmt_pkg::res_type mk_res(
      input logic [fsmt_pkg::STATUS_W-1:0] status,
      input logic                          has,
      input logic [fsmt_pkg::SLOT_W-1:0]   slot9,
      input logic [fsmt_pkg::COUNT_W-1:0]  writes,
      input fsmt_pkg::cfg_type             cfg_v
   );
      fsmt_pkg::res_type r;
      r.status          = status;
      r.found_slot      = has ? slot9 : '0;
      r.flash_sector    = has ? cfg_v.first_sector
                                + (fsmt_pkg::SECTOR_W'(slot9) << cfg_v.group_shift) : '0;
      r.write_count     = has ? writes : '0;
      return r;
   endfunction

   assign active_n = (32'(cfg.logical_count) >= SLOTS) ? NW'(SLOTS) : NW'(cfg.logical_count);
   assign active_p = PW'(active_n);
   assign limit    = (op_ff == fsmt_pkg::OP_SCRUB) ? PW'(SLOTS) : active_p;
   assign in_range = cur_ff < limit;
   assign slot_p   = PW'(req_ch.slot);
   assign start_w  = (slot_p < active_p) ? slot_p : active_p - PW'(1);

   assign match_id = mem_rd_data.valid && (mem_rd_data.owner == id_ff);
   assign stale    = mem_rd_data.valid
                     && (mem_rd_data.owner >= fsmt_pkg::ID_W'(cfg.logical_count));
   assign next_writes = (mem_rd_data.writes == fsmt_pkg::COUNT_MAX) ?
                        mem_rd_data.writes : mem_rd_data.writes + fsmt_pkg::COUNT_W'(1);

   always_comb begin
      hit = 1'b0;
      if (chk_valid_ff) begin
         unique case (op_ff)
            fsmt_pkg::OP_LOOKUP: hit = match_id;
            fsmt_pkg::OP_RECORD: hit = match_id;
            fsmt_pkg::OP_ALLOC:  hit = !mem_rd_data.valid;
            default:             hit = 1'b0;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign res_valid    = (state_ff == S_ISSUE);
   assign res          = res_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      chk_in       = chk_ff;
      chk_valid_in = chk_valid_ff;
      down_in      = down_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_ff[AW-1:0];
      mem_wr_data  = '0;
      mem_rd_addr  = cur_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            if (cur_ff == PW'(SLOTS - 1)) begin
               cur_in   = '0;
               state_in = S_IDLE;
            end else begin
               cur_in = cur_ff + PW'(1);
            end
         end

         S_IDLE: begin
            if (req_ch.valid) begin
               op_in        = req_ch.operation;
               id_in        = req_ch.map_id;
               end_in       = req_ch.slot_end;
               chk_valid_in = 1'b0;
               down_in      = 1'b0;
               unique case (req_ch.operation)
                  fsmt_pkg::OP_LOOKUP, fsmt_pkg::OP_RECORD, fsmt_pkg::OP_SCRUB: begin
                     cur_in   = '0;
                     state_in = S_SCAN;
                  end
                  fsmt_pkg::OP_ALLOC: begin
                     if (active_n == '0) begin
                        res_in   = mk_res(fsmt_pkg::ST_NO_FREE, 1'b0, '0, '0, cfg);
                        state_in = S_ISSUE;
                     end else begin
                        cur_in   = start_w;
                        start_in = start_w;
                        state_in = S_SCAN;
                     end
                  end
                  fsmt_pkg::OP_DELETE: begin
                     if (req_ch.slot > req_ch.slot_end) begin
                        res_in   = mk_res(fsmt_pkg::ST_BAD, 1'b0, '0, '0, cfg);
                        state_in = S_ISSUE;
                     end else begin
                        cur_in   = slot_p;
                        state_in = S_DEL;
                     end
                  end
                  default: begin
                     res_in   = mk_res(fsmt_pkg::ST_BAD, 1'b0, '0, '0, cfg);
                     state_in = S_ISSUE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (hit) begin
               mem_wr_addr = chk_ff;
               state_in    = S_ISSUE;
               unique case (op_ff)
                  fsmt_pkg::OP_RECORD: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{valid: 1'b1, owner: id_ff, writes: next_writes};
                     res_in = mk_res(fsmt_pkg::ST_OK, 1'b1, fsmt_pkg::SLOT_W'(chk_ff),
                                     next_writes, cfg);
                  end
                  fsmt_pkg::OP_ALLOC: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{valid: 1'b1, owner: id_ff,
                                     writes: fsmt_pkg::COUNT_W'(1)};
                     res_in = mk_res(fsmt_pkg::ST_OK, 1'b1, fsmt_pkg::SLOT_W'(chk_ff),
                                     fsmt_pkg::COUNT_W'(1), cfg);
                  end
                  default: begin
                     res_in = mk_res(fsmt_pkg::ST_OK, 1'b1, fsmt_pkg::SLOT_W'(chk_ff),
                                     mem_rd_data.writes, cfg);
                  end
               endcase
            end else begin
               // drop stale owners one entry behind the read
               if (op_ff == fsmt_pkg::OP_SCRUB && chk_valid_ff && stale) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = chk_ff;
               end
               if (in_range) begin
                  chk_in       = cur_ff[AW-1:0];
                  chk_valid_in = 1'b1;
                  cur_in       = down_ff ? cur_ff - PW'(1) : cur_ff + PW'(1);
               end else if (chk_valid_ff) begin
                  chk_valid_in = 1'b0;
               end else if (op_ff == fsmt_pkg::OP_ALLOC && !down_ff) begin
                  down_in = 1'b1;
                  cur_in  = start_ff - PW'(1);
               end else begin
                  state_in = S_ISSUE;
                  if (op_ff == fsmt_pkg::OP_ALLOC) begin
                     res_in = mk_res(fsmt_pkg::ST_NO_FREE, 1'b0, '0, '0, cfg);
                  end else if (op_ff == fsmt_pkg::OP_SCRUB) begin
                     res_in = mk_res(fsmt_pkg::ST_OK, 1'b0, '0, '0, cfg);
                  end else begin
                     res_in = mk_res(fsmt_pkg::ST_NOT_FOUND, 1'b0, '0, '0, cfg);
                  end
               end
            end
         end

         S_DEL: begin
            if (cur_ff <= PW'(end_ff) && cur_ff < PW'(SLOTS)) begin
               mem_wr_en = 1'b1;
               cur_in    = cur_ff + PW'(1);
            end else begin
               res_in   = mk_res(fsmt_pkg::ST_OK, 1'b0, '0, '0, cfg);
               state_in = S_ISSUE;
            end
         end

         S_ISSUE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_ff       <= '0;
         chk_valid_ff <= 1'b0;
         down_ff      <= 1'b0;
         op_ff        <= fsmt_pkg::OP_LOOKUP;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         chk_valid_ff <= chk_valid_in;
         down_ff      <= down_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff   <= chk_in;
      id_ff    <= id_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      res_ff   <= res_in;
   end

endmodule

>>> src/fsmt_rsp.sv
`timescale 1ns / 1ps

module fsmt_rsp (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   input  fsmt_pkg::res_type res,
   output logic              res_take,
   fsmt_rsp_if.source        rsp_ch
);

   logic              valid_ff, valid_in;
   fsmt_pkg::res_type data_ff, data_in;

   assign res_take = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_valid && res_take) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.status       = data_ff.status;
   assign rsp_ch.found_slot   = data_ff.found_slot;
   assign rsp_ch.flash_sector = data_ff.flash_sector;
   assign rsp_ch.write_count  = data_ff.write_count;

endmodule

>>> src/flash_sector_map_table_core.sv
`timescale 1ns / 1ps

// Flash sector-group slot table.
// req_ch takes one request at a time: lookup, allocate, record_write, delete range or
// scrub. rsp_ch returns exactly one result per request: status, slot, physical sector
// (first_sector + slot << group_shift) and write count. csr_ch writes first_sector,
// logical_count and group_shift; it is always ready. The user must write csr_ch only while
// idle; the block itself does not enforce this. Each slot lives in a single-port-write,
// single-port-read table with a registered read; a scan reads one slot per cycle, and
// checks each slot in the cycle after its read.
// Lookup and record_write scan the n active slots up from slot 0 (none when n is 0);
// allocate scans up from the requested slot (clamped to the last active slot), then
// down below it; scrub scans all SLOTS slots; delete clears the range slot by slot.
// Invalid or reversed requests and allocate with no active slot go straight to a result.
// After reset the block clears every slot, one per cycle, before req_ch becomes
// ready; configuration writes are taken during that pass.
// A stalled rsp_ch holds the result in the output register; the next request is still
// taken and held back only when its own result is ready to leave.
module flash_sector_map_table_core #(
   parameter int SLOTS = fsmt_pkg::SLOTS_DEF
) (
   input logic          clock,
   input logic          reset,
   fsmt_req_if.sink     req_ch,
   fsmt_rsp_if.source   rsp_ch,
   fsmt_csr_if.sink     csr_ch
);

   localparam int AW = $clog2(SLOTS);

   fsmt_pkg::cfg_type   cfg;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   fsmt_pkg::entry_type mem_wr_data;
   logic [AW-1:0]       mem_rd_addr;
   fsmt_pkg::entry_type mem_rd_data;
   logic                res_valid;
   fsmt_pkg::res_type   res;
   logic                res_take;

   fsmt_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   fsmt_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fsmt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_ch      (req_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   fsmt_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take),
      .rsp_ch    (rsp_ch)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !mem_wr_en)
      else $error("table written while idle");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_take |=> rsp_ch.valid)
      else $error("result lost on the way to the output register");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != fsmt_pkg::ST_OK
      |-> rsp_ch.found_slot == '0 && rsp_ch.write_count == '0
          && rsp_ch.flash_sector == '0)
      else $error("failed request carries slot data");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic [fsmt_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [fsmt_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [fsmt_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int PHASE_ITEMS    = 146;
   localparam int SLOT_MAX       = fsmt_pkg::SLOTS_DEF - 1;

   localparam fsmt_pkg::res_type NO_RES = '0;

   typedef struct packed {
      logic [fsmt_pkg::OP_W-1:0]   op;
      logic [fsmt_pkg::ID_W-1:0]   id;
      logic [fsmt_pkg::SLOT_W-1:0] first;
      logic [fsmt_pkg::SLOT_W-1:0] last;
      logic                        fixed;
      fsmt_pkg::res_type           want;
   } map_req_row_type;

   localparam int DIRECTED_COUNT = 21;
   localparam map_req_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{fsmt_pkg::OP_LOOKUP, 16'h0000, 9'd0,   9'd0,   1'b1,
        '{fsmt_pkg::ST_NOT_FOUND, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_RECORD, 16'h0005, 9'd0,   9'd0,   1'b1,
        '{fsmt_pkg::ST_NOT_FOUND, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_ALLOC,  16'hFFFF, 9'd0,   9'd0,   1'b1,
        '{fsmt_pkg::ST_OK, 9'd0, 24'd0, 16'd1}},
      '{fsmt_pkg::OP_ALLOC,  16'h0000, 9'd511, 9'd0,   1'b1,
        '{fsmt_pkg::ST_OK, 9'd511, 24'd511, 16'd1}},
      '{fsmt_pkg::OP_ALLOC,  16'h1234, 9'd511, 9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_ALLOC,  16'h1234, 9'd0,   9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_LOOKUP, 16'h1234, 9'd0,   9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_RECORD, 16'h1234, 9'd0,   9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_RECORD, 16'hFFFF, 9'd0,   9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_DELETE, 16'h0000, 9'd5,   9'd4,   1'b1,
        '{fsmt_pkg::ST_BAD, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_DELETE, 16'h0000, 9'd1,   9'd1,   1'b1,
        '{fsmt_pkg::ST_OK, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_LOOKUP, 16'h1234, 9'd0,   9'd0,   1'b0, NO_RES},
      '{OP_RSVD5,            16'hFFFF, 9'd511, 9'd511, 1'b1,
        '{fsmt_pkg::ST_BAD, 9'd0, 24'd0, 16'd0}},
      '{OP_RSVD6,            16'h0000, 9'd0,   9'd0,   1'b1,
        '{fsmt_pkg::ST_BAD, 9'd0, 24'd0, 16'd0}},
      '{OP_RSVD7,            16'h5A5A, 9'd256, 9'd255, 1'b1,
        '{fsmt_pkg::ST_BAD, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_SCRUB,  16'h0000, 9'd0,   9'd0,   1'b1,
        '{fsmt_pkg::ST_OK, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_LOOKUP, 16'hFFFF, 9'd0,   9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_LOOKUP, 16'h0000, 9'd0,   9'd0,   1'b0, NO_RES},
      '{fsmt_pkg::OP_DELETE, 16'h0000, 9'd0,   9'd511, 1'b1,
        '{fsmt_pkg::ST_OK, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_LOOKUP, 16'h0000, 9'd0,   9'd0,   1'b1,
        '{fsmt_pkg::ST_NOT_FOUND, 9'd0, 24'd0, 16'd0}},
      '{fsmt_pkg::OP_ALLOC,  16'h00AA, 9'd300, 9'd0,   1'b0, NO_RES}
   };

   typedef struct {
      bit                fixed;
      fsmt_pkg::res_type want;
   } typed_result_type;

   logic clock = 1'b0;
   logic reset;

   fsmt_req_if req_ch ();
   fsmt_rsp_if rsp_ch ();
   fsmt_csr_if csr_ch ();

   flash_sector_map_table_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   fsmt_pkg::cfg_type map_cfg = '{fsmt_pkg::FIRST_SECTOR_RST, fsmt_pkg::LOGICAL_COUNT_RST,
                                  fsmt_pkg::GROUP_SHIFT_RST};
   bit                            map_valid [fsmt_pkg::SLOTS_DEF];
   logic [fsmt_pkg::ID_W-1:0]     map_owner [fsmt_pkg::SLOTS_DEF];
   logic [fsmt_pkg::COUNT_W-1:0]  map_writes [fsmt_pkg::SLOTS_DEF];

   fsmt_pkg::res_type pending_results [$];
   typed_result_type  typed_results [$];
   fsmt_pkg::res_type guess;
   typed_result_type  row_want;
   int                mismatches = 0;
   int                quiet_cycles = 0;
   bit                accepted;

   bit bursts_on = 1'b0;
   int hold_orders = 0;
   int holds_served = 0;
   int hold_left = 0;
   int rsp_gap_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_owner(logic [fsmt_pkg::ID_W-1:0] id, int n);
      for (int i = 0; i < n; i++)
         if (map_valid[i] && map_owner[i] == id)
            return i;
      return -1;
   endfunction

   function automatic fsmt_pkg::res_type slot_result(int at);
      fsmt_pkg::res_type r;
      r.status       = fsmt_pkg::ST_OK;
      r.found_slot   = fsmt_pkg::SLOT_W'(at);
      r.flash_sector = map_cfg.first_sector
                       + (fsmt_pkg::SECTOR_W'(at) << map_cfg.group_shift);
      r.write_count  = map_writes[at];
      return r;
   endfunction

   function automatic fsmt_pkg::res_type predict_map_op(
      logic [fsmt_pkg::OP_W-1:0] op, logic [fsmt_pkg::ID_W-1:0] id,
      logic [fsmt_pkg::SLOT_W-1:0] first, logic [fsmt_pkg::SLOT_W-1:0] last);
      int                n;
      int                at;
      int                start;
      fsmt_pkg::res_type r;
      n  = (map_cfg.logical_count > fsmt_pkg::SLOTS_DEF) ? fsmt_pkg::SLOTS_DEF
                                                         : int'(map_cfg.logical_count);
      r  = '0;
      at = -1;
      case (op)
         fsmt_pkg::OP_LOOKUP: begin
            at = find_owner(id, n);
            if (at < 0) r.status = fsmt_pkg::ST_NOT_FOUND;
            else r = slot_result(at);
         end
         fsmt_pkg::OP_ALLOC: begin
            if (n != 0) begin
               start = (first < n) ? int'(first) : n - 1;
               for (int i = start; i < n && at < 0; i++)
                  if (!map_valid[i]) at = i;
               for (int i = start; i > 0 && at < 0; i--)
                  if (!map_valid[i - 1]) at = i - 1;
            end
            if (at < 0) begin
               r.status = fsmt_pkg::ST_NO_FREE;
            end else begin
               map_valid[at]  = 1'b1;
               map_owner[at]  = id;
               map_writes[at] = 16'd1;
               r = slot_result(at);
            end
         end
         fsmt_pkg::OP_RECORD: begin
            at = find_owner(id, n);
            if (at < 0) begin
               r.status = fsmt_pkg::ST_NOT_FOUND;
            end else begin
               if (map_writes[at] != fsmt_pkg::COUNT_MAX)
                  map_writes[at] = map_writes[at] + 16'd1;
               r = slot_result(at);
            end
         end
         fsmt_pkg::OP_DELETE: begin
            if (first > last) r.status = fsmt_pkg::ST_BAD;
            else for (int i = first; i <= last; i++) map_valid[i] = 1'b0;
         end
         fsmt_pkg::OP_SCRUB: begin
            for (int i = 0; i < fsmt_pkg::SLOTS_DEF; i++)
               if (map_valid[i] && map_owner[i] >= map_cfg.logical_count) map_valid[i] = 1'b0;
         end
         default: r.status = fsmt_pkg::ST_BAD;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         accepted = 1'b0;
         if (csr_ch.valid && csr_ch.ready) begin
            accepted = 1'b1;
            case (csr_ch.index)
               fsmt_pkg::IDX_FIRST_SECTOR:
                  map_cfg.first_sector  = csr_ch.data[fsmt_pkg::SECTOR_W-1:0];
               fsmt_pkg::IDX_LOGICAL_COUNT:
                  map_cfg.logical_count = csr_ch.data[fsmt_pkg::LCOUNT_W-1:0];
               fsmt_pkg::IDX_GROUP_SHIFT:
                  map_cfg.group_shift   = csr_ch.data[fsmt_pkg::SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            accepted = 1'b1;
            guess = predict_map_op(req_ch.operation, req_ch.map_id, req_ch.slot,
                                   req_ch.slot_end);
            if (typed_results.size() != 0) begin
               row_want = typed_results.pop_front();
               if (row_want.fixed) guess = row_want.want;
            end
            pending_results.push_back(guess);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            accepted = 1'b1;
            if (pending_results.size() == 0) begin
               $error("result with no request outstanding");
               mismatches++;
            end else begin
               guess = pending_results.pop_front();
               if (rsp_ch.status !== guess.status) begin
                  $error("status: expected %0d, got %0d", guess.status, rsp_ch.status);
                  mismatches++;
               end
               if (rsp_ch.found_slot !== guess.found_slot) begin
                  $error("found_slot: expected %0d, got %0d", guess.found_slot,
                         rsp_ch.found_slot);
                  mismatches++;
               end
               if (rsp_ch.flash_sector !== guess.flash_sector) begin
                  $error("flash_sector: expected %0h, got %0h", guess.flash_sector,
                         rsp_ch.flash_sector);
                  mismatches++;
               end
               if (rsp_ch.write_count !== guess.write_count) begin
                  $error("write_count: expected %0d, got %0d", guess.write_count,
                         rsp_ch.write_count);
                  mismatches++;
               end
            end
         end
         quiet_cycles = accepted ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (holds_served != hold_orders) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap_left != 0) begin
         rsp_gap_left <= rsp_gap_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         rsp_gap_left <= int'($urandom_range(0, 8));
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_request(input logic [fsmt_pkg::OP_W-1:0] op,
                               input logic [fsmt_pkg::ID_W-1:0] id,
                               input logic [fsmt_pkg::SLOT_W-1:0] first,
                               input logic [fsmt_pkg::SLOT_W-1:0] last);
      int gap;
      gap = (bursts_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 9)) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.map_id    <= id;
      req_ch.slot      <= first;
      req_ch.slot_end  <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_register(input logic [fsmt_pkg::CSR_IDX_W-1:0] index,
                                 input logic [fsmt_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic write_settings(input logic [fsmt_pkg::SECTOR_W-1:0] first,
                                 input logic [fsmt_pkg::LCOUNT_W-1:0] count,
                                 input logic [fsmt_pkg::SHIFT_W-1:0] shift);
      write_register(fsmt_pkg::IDX_FIRST_SECTOR, first);
      write_register(fsmt_pkg::IDX_LOGICAL_COUNT, fsmt_pkg::CSR_DATA_W'(count));
      write_register(fsmt_pkg::IDX_GROUP_SHIFT, fsmt_pkg::CSR_DATA_W'(shift));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic settle_table();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input logic [fsmt_pkg::SECTOR_W-1:0] first,
                            input logic [fsmt_pkg::LCOUNT_W-1:0] count,
                            input logic [fsmt_pkg::SHIFT_W-1:0] shift, input bit bursts,
                            input bit squeeze);
      logic [fsmt_pkg::ID_W-1:0]   id_pool [8];
      logic [fsmt_pkg::OP_W-1:0]   op;
      logic [fsmt_pkg::ID_W-1:0]   id;
      logic [fsmt_pkg::SLOT_W-1:0] lo;
      logic [fsmt_pkg::SLOT_W-1:0] hi;
      int                          pick;
      int                          span;
      settle_table();
      write_settings(first, count, shift);
      bursts_on = bursts;
      for (int i = 0; i < 8; i++)
         case (i % 3)
            0: id_pool[i] = fsmt_pkg::ID_W'($urandom_range(0, 15));
            1: id_pool[i] = fsmt_pkg::ID_W'($urandom_range(0, 1023));
            default: id_pool[i] = fsmt_pkg::ID_W'($urandom);
         endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         // stall the results while requests keep coming
         if (squeeze && k == 20) hold_orders++;
         pick = $urandom_range(0, 99);
         if (pick < 25) op = fsmt_pkg::OP_LOOKUP;
         else if (pick < 55) op = fsmt_pkg::OP_ALLOC;
         else if (pick < 78) op = fsmt_pkg::OP_RECORD;
         else if (pick < 90) op = fsmt_pkg::OP_DELETE;
         else if (pick < 94) op = fsmt_pkg::OP_SCRUB;
         else op = fsmt_pkg::OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
         id = ($urandom_range(0, 9) == 0) ? fsmt_pkg::ID_W'($urandom)
                                          : id_pool[$urandom_range(0, 7)];
         lo = fsmt_pkg::SLOT_W'($urandom);
         span = int'(lo) + int'($urandom_range(0, 15));
         hi = ($urandom_range(0, 3) == 0) ? fsmt_pkg::SLOT_W'($urandom)
              : fsmt_pkg::SLOT_W'((span > SLOT_MAX) ? SLOT_MAX : span);
         send_request(op, id, lo, hi);
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = fsmt_pkg::OP_LOOKUP;
      req_ch.map_id    = '0;
      req_ch.slot      = '0;
      req_ch.slot_end  = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = fsmt_pkg::IDX_FIRST_SECTOR;
      csr_ch.data      = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      bursts_on = 1'b1;
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         typed_results.push_back('{DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want});
         send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].id, DIRECTED_ROWS[r].first,
                      DIRECTED_ROWS[r].last);
      end
      req_ch.valid <= 1'b0;

      run_phase(24'hFFFFFF, 10'd16, 3'd7, 1'b1, 1'b1);
      run_phase(fsmt_pkg::SECTOR_W'($urandom), 10'd512,
                fsmt_pkg::SHIFT_W'($urandom_range(0, 6)), 1'b1, 1'b0);
      run_phase(24'h000000, 10'd0, 3'd3, 1'b1, 1'b0);
      run_phase(24'hFFFFF0, 10'd1, 3'd6, 1'b1, 1'b0);
      run_phase(fsmt_pkg::SECTOR_W'($urandom), 10'd1023,
                fsmt_pkg::SHIFT_W'($urandom_range(0, 7)), 1'b1, 1'b0);
      run_phase(fsmt_pkg::SECTOR_W'($urandom), 10'd8, 3'd5, 1'b1, 1'b0);
      run_phase(fsmt_pkg::SECTOR_W'($urandom), 10'd64,
                fsmt_pkg::SHIFT_W'($urandom_range(0, 7)), 1'b1, 1'b0);
      run_phase(fsmt_pkg::SECTOR_W'($urandom), 10'd512, 3'd0, 1'b0, 1'b0);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (fsmt_pkg::SLOTS_DEF + 8) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
